// ----- rtl/core/rmte_pkg.sv -----
// Shared constants, item type and arctangent table for the matrix-to-angles block.
package rmte_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int N_ITER       = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int SQRT_STEPS   = 15;
    localparam int W_IN         = 16;
    localparam int W_OP         = 17;
    localparam int W_XY         = 33;
    localparam int W_Z          = 24;
    localparam int W_RAD        = 29;
    localparam int W_YAW        = 15;
    localparam int W_PITCH      = 14;
    localparam int LIM_YAW      = 11520;
    localparam int LIM_PITCH    = 5760;
    localparam int Q_ONE        = 16384;
    localparam int DEG180_Z     = 2949120;

    typedef struct packed {
        logic                   sing;
        logic signed [W_OP-1:0] yaw_y;
        logic signed [W_OP-1:0] yaw_x;
        logic signed [W_OP-1:0] roll_y;
        logic signed [W_OP-1:0] roll_x;
        logic signed [W_IN-1:0] s;
        logic [W_RAD-1:0]       rad;
    } t_front_item;

    function automatic logic signed [W_Z-1:0] atan_tab(input int i);
        logic signed [W_Z-1:0] v;
        case (i)
            0:       v = 24'sd737280;
            1:       v = 24'sd435242;
            2:       v = 24'sd229970;
            3:       v = 24'sd116736;
            4:       v = 24'sd58595;
            5:       v = 24'sd29326;
            6:       v = 24'sd14667;
            7:       v = 24'sd7334;
            8:       v = 24'sd3667;
            9:       v = 24'sd1833;
            10:      v = 24'sd917;
            11:      v = 24'sd458;
            12:      v = 24'sd229;
            13:      v = 24'sd115;
            14:      v = 24'sd57;
            15:      v = 24'sd29;
            16:      v = 24'sd14;
            17:      v = 24'sd7;
            18:      v = 24'sd4;
            19:      v = 24'sd2;
            20:      v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/rmte_fifo.sv -----
// Two-entry item queue between front and back.
module rmte_fifo
    import rmte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_front_item i_data,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_front_item o_data
);
    t_front_item r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push_ok, pop_ok;

    assign o_full   = (r_cnt == 2'd2);
    assign o_empty  = (r_cnt == 2'd0);
    assign o_data   = r_mem[r_rp];
    assign push_ok  = i_push && !o_full;
    assign pop_ok   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= ~r_wp;
            if (pop_ok) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
    end
endmodule

// ----- rtl/core/rmte_front.sv -----
// Front end: classifies the matrix and forms the operands of each angle.
module rmte_front
    import rmte_pkg::*;
(
    input  logic signed [rmte_pkg::W_IN-1:0] i_r00,
    input  logic signed [rmte_pkg::W_IN-1:0] i_r02,
    input  logic signed [rmte_pkg::W_IN-1:0] i_r10,
    input  logic signed [rmte_pkg::W_IN-1:0] i_r11,
    input  logic signed [rmte_pkg::W_IN-1:0] i_r12,
    input  logic signed [rmte_pkg::W_IN-1:0] i_r20,
    input  logic signed [rmte_pkg::W_IN-1:0] i_r22,
    output rmte_pkg::t_front_item            o_item
);
    logic                   sing;
    logic signed [W_IN-1:0] s;
    logic signed [31:0]     sq;

    always_comb begin
        sing = (i_r00 == 16'sd16384) || (i_r00 == -16'sd16384);
        if (i_r10 > 16'sd16384) s = 16'sd16384;
        else if (i_r10 < -16'sd16384) s = -16'sd16384;
        else s = i_r10;
        sq = 32'(s) * 32'(s);
        o_item.sing   = sing;
        o_item.yaw_y  = sing ? W_OP'(i_r02) : -W_OP'(i_r20);
        o_item.yaw_x  = sing ? W_OP'(i_r22) : W_OP'(i_r00);
        o_item.roll_y = -W_OP'(i_r12);
        o_item.roll_x = W_OP'(i_r11);
        o_item.s      = s;
        o_item.rad    = W_RAD'(32'sd268435456 - sq);
    end
endmodule

// ----- rtl/core/rmte_cordic.sv -----
// Pipelined vectoring CORDIC atan2, result in 2^-14 degree.
module rmte_cordic
    import rmte_pkg::*;
(
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [rmte_pkg::W_OP-1:0] i_y,
    input  logic signed [rmte_pkg::W_OP-1:0] i_x,
    output logic signed [rmte_pkg::W_Z-1:0]  o_z
);
    logic signed [W_XY-1:0] r_x  [N_ITER+1];
    logic signed [W_XY-1:0] r_y  [N_ITER+1];
    logic signed [W_Z-1:0]  r_z  [N_ITER+1];
    logic                   r_zf [N_ITER+1];
    logic signed [W_XY-1:0] x0, y0;

    assign x0 = W_XY'(i_x) <<< 14;
    assign y0 = W_XY'(i_y) <<< 14;

    // quadrant pre-rotation for negative x
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zf[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -x0;
                r_y[0] <= -y0;
                r_z[0] <= (i_y >= 0) ? W_Z'(DEG180_Z) : -W_Z'(DEG180_Z);
            end else begin
                r_x[0] <= x0;
                r_y[0] <= y0;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N_ITER; i++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zf[i+1] <= r_zf[i];
                if (r_y[i] < 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_tab(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_tab(i);
                end
            end
        end
    end

    assign o_z = r_zf[N_ITER] ? '0 : r_z[N_ITER];
endmodule

// ----- rtl/core/rmte_back.sv -----
// Back end: square-root pipeline, three CORDIC pipelines, rounding and output register.
module rmte_back
    import rmte_pkg::*;
(
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_have,
    input  rmte_pkg::t_front_item                i_item,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [rmte_pkg::W_YAW-1:0]    o_yaw,
    output logic signed [rmte_pkg::W_PITCH-1:0]  o_pitch,
    output logic signed [rmte_pkg::W_YAW-1:0]    o_roll
);
    localparam int DEPTH = SQRT_STEPS + 1 + N_ITER + 1;

    logic              en;
    logic              r_vld  [DEPTH];
    t_front_item       r_itm  [SQRT_STEPS+1];
    logic [W_RAD-1:0]  r_v    [SQRT_STEPS+1];
    logic [W_RAD-1:0]  r_res  [SQRT_STEPS+1];
    logic              r_sing [N_ITER+1];
    logic signed [W_Z-1:0] z_yaw, z_pitch, z_roll;

    assign en    = !o_valid || !i_stall;
    assign o_pop = en && i_have;

    function automatic logic signed [W_YAW-1:0] rnd(input logic signed [W_Z-1:0] z,
                                                   input int lim);
        logic [W_Z-1:0] mag;
        logic [W_Z-1:0] q;
        logic [W_Z-1:0] ql;
        mag = (z < 0) ? W_Z'(-z) : W_Z'(z);
        q   = (mag + W_Z'(128)) >> 8;
        ql  = (q > W_Z'(lim)) ? W_Z'(lim) : q;
        return (z < 0) ? -W_YAW'(ql) : W_YAW'(ql);
    endfunction

    // integer square root, one result bit per stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_itm[0] <= i_item;
            r_v[0]   <= i_item.rad;
            r_res[0] <= '0;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sq
        localparam logic [W_RAD-1:0] BIT = W_RAD'(1) << (2 * (SQRT_STEPS - 1 - j));
        logic [W_RAD:0] trial;
        assign trial = {1'b0, r_res[j]} + {1'b0, BIT};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_itm[j+1] <= r_itm[j];
                if ({1'b0, r_v[j]} >= trial) begin
                    r_v[j+1]   <= W_RAD'({1'b0, r_v[j]} - trial);
                    r_res[j+1] <= (r_res[j] >> 1) + BIT;
                end else begin
                    r_v[j+1]   <= r_v[j];
                    r_res[j+1] <= r_res[j] >> 1;
                end
            end
        end
    end

    rmte_cordic u_yaw (
        .i_clk(i_clk), .i_en(en),
        .i_y(r_itm[SQRT_STEPS].yaw_y), .i_x(r_itm[SQRT_STEPS].yaw_x), .o_z(z_yaw));
    rmte_cordic u_pitch (
        .i_clk(i_clk), .i_en(en),
        .i_y(W_OP'(r_itm[SQRT_STEPS].s)), .i_x(W_OP'(r_res[SQRT_STEPS])), .o_z(z_pitch));
    rmte_cordic u_roll (
        .i_clk(i_clk), .i_en(en),
        .i_y(r_itm[SQRT_STEPS].roll_y), .i_x(r_itm[SQRT_STEPS].roll_x), .o_z(z_roll));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sing[0] <= r_itm[SQRT_STEPS].sing;
            for (int k = 0; k < N_ITER; k++) r_sing[k+1] <= r_sing[k];
            o_yaw   <= rnd(z_yaw, LIM_YAW);
            o_pitch <= r_sing[N_ITER] ? '0 : W_PITCH'(rnd(z_pitch, LIM_PITCH));
            o_roll  <= r_sing[N_ITER] ? '0 : rnd(z_roll, LIM_YAW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_vld[k] <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_have;
            for (int k = 1; k < DEPTH; k++) r_vld[k] <= r_vld[k-1];
            o_valid <= r_vld[DEPTH-1];
        end
    end
endmodule

// ----- rtl/core/rotation_matrix_to_euler_angles.sv -----
// Top level: rotation matrix (Q1.14) to yaw, pitch and roll in 1/64 degree.
// Path from input accept to output valid: the queue, operand register, 15 square-root
//   stages, CORDIC_STEPS+1 CORDIC stages and output register; a stalled output holds
//   the back part of this path.
// Throughput: one item per cycle; the whole back pipeline advances together and
//   holds while the output item is stalled.
// Reset: synchronous, active low; clears queue and valid bits, no datapath state.
module rotation_matrix_to_euler_angles
    import rmte_pkg::*;
(
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [rmte_pkg::W_IN-1:0]     i_r00,
    input  logic signed [rmte_pkg::W_IN-1:0]     i_r02,
    input  logic signed [rmte_pkg::W_IN-1:0]     i_r10,
    input  logic signed [rmte_pkg::W_IN-1:0]     i_r11,
    input  logic signed [rmte_pkg::W_IN-1:0]     i_r12,
    input  logic signed [rmte_pkg::W_IN-1:0]     i_r20,
    input  logic signed [rmte_pkg::W_IN-1:0]     i_r22,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [rmte_pkg::W_YAW-1:0]    o_yaw,
    output logic signed [rmte_pkg::W_PITCH-1:0]  o_pitch,
    output logic signed [rmte_pkg::W_YAW-1:0]    o_roll
);
    t_front_item f_item, q_item;
    logic        q_full, q_empty, pop;

    // front: gimbal-lock test, sine clamp and 1 - s^2 for the cosine
    rmte_front u_front (
        .i_r00(i_r00), .i_r02(i_r02), .i_r10(i_r10), .i_r11(i_r11),
        .i_r12(i_r12), .i_r20(i_r20), .i_r22(i_r22), .o_item(f_item));

    // short queue decouples the input stall from the back pipeline
    rmte_fifo u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_valid), .i_data(f_item),
        .i_pop(pop), .o_full(q_full), .o_empty(q_empty), .o_data(q_item));

    assign o_stall = q_full;

    rmte_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_have(!q_empty), .i_item(q_item), .o_pop(pop),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_yaw(o_yaw), .o_pitch(o_pitch), .o_roll(o_roll));
endmodule
